// ===== design/kto_pkg.sv =====
package kto_pkg;

    localparam logic [2:0] MODE_UPSERT = 3'd0;
    localparam logic [2:0] MODE_FLAGS  = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_LOOKUP = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_LIST   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic [63:0]        key;
        logic               has_node;
        logic signed [7:0]  link_rssi;
        logic signed [11:0] link_snr;
        logic [7:0]         path_hash_size;
        logic [7:0]         path_hop_count;
        logic               want_favorite;
        logic               want_muted;
        logic [31:0]        now_ms;
        logic [5:0]         max_count;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        out_key;
        logic [31:0]        out_seq;
        logic [31:0]        out_created_ms;
        logic [31:0]        out_updated_ms;
        logic signed [7:0]  out_link_rssi;
        logic signed [11:0] out_link_snr;
        logic [7:0]         out_path_hash_size;
        logic [7:0]         out_path_hops;
        logic               out_favorite;
        logic               out_muted;
        logic               last;
    } t_out;

    // entry payload without the key; flags bit 0 favorite, bit 1 muted
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] created;
        logic [31:0] updated;
        logic [7:0]  rssi;
        logic [11:0] snr;
        logic [7:0]  path_size;
        logic [7:0]  hops;
        logic [1:0]  flags;
    } t_entry;

endpackage

// ===== design/kto_cell.sv =====
module kto_cell
    import kto_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_wr,
    input  logic [KEY_BITS-1:0] i_wkey,
    input  t_entry              i_wdata,
    input  logic                i_shift,
    input  logic [KEY_BITS-1:0] i_nkey,
    input  t_entry              i_ndata,
    input  logic [KEY_BITS-1:0] i_key,
    output logic [KEY_BITS-1:0] o_key,
    output t_entry              o_data,
    output logic                o_match
);

    logic [KEY_BITS-1:0] r_key;
    t_entry              r_data;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_key  <= i_wkey;
            r_data <= i_wdata;
        end else if (i_shift) begin
            r_key  <= i_nkey;
            r_data <= i_ndata;
        end
    end

    assign o_key   = r_key;
    assign o_data  = r_data;
    assign o_match = (r_key == i_key);

endmodule

// ===== design/keyed_table_oldest_eviction.sv =====
// Channel  Direction  Signals                      Payload
// input    in         i_valid / o_ready / i_data   t_in (one table operation)
// output   out        o_valid / i_ready / o_data   t_out (one result)
//
// One operation at a time: lookup, set flags, delete and clear pass through
// find and decode, a hit or room-left upsert also through the upsert state,
// plus output wait. Upsert into a full table adds a scan over the cells for
// the lowest sequence; list recent runs one scan over the cells per result.
// Reset empties the table and sets the sequence to one; no clearing pass.
// A stalled output holds the sequencer in its decode, upsert and list states.
module keyed_table_oldest_eviction
    import kto_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = (CW > 6) ? CW : 6;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIND = 6'b000010,
        S_DEC  = 6'b000100,
        S_SCAN = 6'b001000,
        S_UPS  = 6'b010000,
        S_LIST = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_in                 r_in;
    logic [CW-1:0]       r_count, n_count;
    logic [31:0]         r_nseq, n_nseq;
    logic                r_hit;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_slot, n_slot;
    logic                r_fresh, n_fresh;
    logic                r_evict, n_evict;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_have, n_have;
    logic [IW-1:0]       r_best, n_best;
    logic [31:0]         r_bseq, n_bseq;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [NW-1:0]       r_n, n_n;
    logic [NW-1:0]       r_k, n_k;
    logic                r_ov, n_ov;
    t_out                r_out, n_out;

    logic [KEY_BITS-1:0] key_m;
    logic [KEY_BITS-1:0] c_key   [CAPACITY];
    t_entry              c_data  [CAPACITY];
    logic [CAPACITY-1:0] c_match;
    logic [CAPACITY-1:0] wr_vec, sh_vec;
    t_entry              w_data;
    logic                find_hit;
    logic [IW-1:0]       find_idx;
    logic                out_free;
    t_entry              cur, scan_e;
    logic [KEY_BITS-1:0] cur_key;
    logic [NW-1:0]       mc_w, cnt_w;

    assign key_m    = r_in.key[KEY_BITS-1:0];
    assign out_free = !r_ov || i_ready;
    assign cur      = c_data[r_idx];
    assign cur_key  = c_key[r_idx];
    assign scan_e   = c_data[r_ptr[IW-1:0]];
    assign mc_w     = NW'(r_in.max_count);
    assign cnt_w    = NW'(r_count);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            kto_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_wr    (wr_vec[g]),
                .i_wkey  (key_m),
                .i_wdata (w_data),
                .i_shift (sh_vec[g]),
                .i_nkey  (c_key[(g + 1 < CAPACITY) ? g + 1 : g]),
                .i_ndata (c_data[(g + 1 < CAPACITY) ? g + 1 : g]),
                .i_key   (key_m),
                .o_key   (c_key[g]),
                .o_data  (c_data[g]),
                .o_match (c_match[g])
            );
        end
    endgenerate

    always_comb begin
        find_hit = 1'b0;
        find_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (c_match[i] && (CW'(i) < r_count)) begin
                find_hit = 1'b1;
                find_idx = IW'(i);
            end
        end
    end

    function automatic t_out mk_out(logic [1:0] st, logic [KEY_BITS-1:0] k, t_entry e,
                                    logic lst);
        t_out o;
        o.status             = st;
        o.out_key            = 64'(k);
        o.out_seq            = e.seq;
        o.out_created_ms     = e.created;
        o.out_updated_ms     = e.updated;
        o.out_link_rssi      = e.rssi;
        o.out_link_snr       = e.snr;
        o.out_path_hash_size = e.path_size;
        o.out_path_hops      = e.hops;
        o.out_favorite       = e.flags[0];
        o.out_muted          = e.flags[1];
        o.last               = lst;
        return o;
    endfunction

    always_comb begin
        t_entry base;
        n_state = r_state;
        n_count = r_count;
        n_nseq  = r_nseq;
        n_slot  = r_slot;
        n_fresh = r_fresh;
        n_evict = r_evict;
        n_ptr   = r_ptr;
        n_have  = r_have;
        n_best  = r_best;
        n_bseq  = r_bseq;
        n_used  = r_used;
        n_n     = r_n;
        n_k     = r_k;
        n_ov    = r_ov && !i_ready;
        n_out   = r_out;
        wr_vec  = '0;
        sh_vec  = '0;
        w_data  = cur;
        base    = c_data[r_slot];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_ov    = 1'b1;
                    n_out   = mk_out(ST_OK, '0, '0, 1'b1);
                    if (r_in.mode == MODE_LIST) begin
                        n_n = (mc_w < cnt_w) ? mc_w : cnt_w;
                        if (r_in.max_count == '0 || r_count == '0) begin
                            n_out.status = ST_NOT_FOUND;
                        end else begin
                            n_ov    = r_ov && !i_ready;
                            n_used  = '0;
                            n_k     = '0;
                            n_ptr   = '0;
                            n_have  = 1'b0;
                            n_evict = 1'b0;
                            n_state = S_SCAN;
                        end
                    end else if (r_in.mode == MODE_CLEAR) begin
                        n_count = '0;
                        n_nseq  = 32'd1;
                    end else if (r_in.mode > MODE_LIST) begin
                        n_out.status = ST_INVALID;
                    end else if (key_m == '0) begin
                        n_out.status = (r_in.mode == MODE_LOOKUP) ? ST_NOT_FOUND
                                                                   : ST_INVALID;
                    end else if (r_in.mode == MODE_UPSERT) begin
                        n_ov    = r_ov && !i_ready;
                        n_fresh = !r_hit;
                        if (r_hit) begin
                            n_slot  = r_idx;
                            n_state = S_UPS;
                        end else if (r_count < CW'(CAPACITY)) begin
                            n_slot  = r_count[IW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_UPS;
                        end else begin
                            n_ptr   = '0;
                            n_have  = 1'b0;
                            n_evict = 1'b1;
                            n_state = S_SCAN;
                        end
                    end else if (!r_hit) begin
                        n_out.status = ST_NOT_FOUND;
                    end else if (r_in.mode == MODE_FLAGS) begin
                        w_data = cur;
                        if (cur.flags != {r_in.want_muted, r_in.want_favorite}) begin
                            w_data.flags   = {r_in.want_muted, r_in.want_favorite};
                            w_data.seq     = r_nseq;
                            w_data.updated = r_in.now_ms;
                            n_nseq         = r_nseq + 32'd1;
                            wr_vec[r_idx]  = 1'b1;
                        end
                        n_out = mk_out(ST_OK, cur_key, w_data, 1'b1);
                    end else if (r_in.mode == MODE_DELETE) begin
                        n_out = mk_out(ST_OK, cur_key, cur, 1'b1);
                        for (int i = 0; i < CAPACITY; i++) begin
                            sh_vec[i] = (IW'(i) >= r_idx) && (CW'(i + 1) < r_count);
                        end
                        n_count = r_count - CW'(1);
                    end else begin
                        n_out = mk_out(ST_OK, cur_key, cur, 1'b1);
                    end
                end
            end
            S_SCAN: begin
                if (r_evict) begin
                    if (!r_have || scan_e.seq < r_bseq) begin
                        n_have = 1'b1;
                        n_best = r_ptr[IW-1:0];
                        n_bseq = scan_e.seq;
                    end
                end else if (!r_used[r_ptr[IW-1:0]]) begin
                    if (!r_have || scan_e.seq > r_bseq) begin
                        n_have = 1'b1;
                        n_best = r_ptr[IW-1:0];
                        n_bseq = scan_e.seq;
                    end
                end
                n_ptr = r_ptr + CW'(1);
                if (r_ptr + CW'(1) == r_count) begin
                    n_state = r_evict ? S_UPS : S_LIST;
                    if (r_evict) begin
                        n_slot = (!r_have || scan_e.seq < r_bseq) ? r_ptr[IW-1:0] : r_best;
                    end
                end
            end
            S_UPS: begin
                if (out_free) begin
                    w_data = base;
                    if (r_fresh) begin
                        w_data         = '0;
                        w_data.created = r_in.now_ms;
                    end
                    w_data.seq     = r_nseq;
                    w_data.updated = r_in.now_ms;
                    if (r_in.has_node) begin
                        w_data.rssi      = r_in.link_rssi;
                        w_data.snr       = r_in.link_snr;
                        w_data.path_size = r_in.path_hash_size;
                        w_data.hops      = r_in.path_hop_count;
                    end
                    wr_vec[r_slot] = 1'b1;
                    n_nseq  = r_nseq + 32'd1;
                    n_ov    = 1'b1;
                    n_out   = mk_out(ST_OK, key_m, w_data, 1'b1);
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_ov           = 1'b1;
                    n_out          = mk_out(ST_OK, c_key[r_best], c_data[r_best],
                                            r_k + NW'(1) == r_n);
                    n_used[r_best] = 1'b1;
                    n_k            = r_k + NW'(1);
                    n_ptr          = '0;
                    n_have         = 1'b0;
                    n_state        = (r_k + NW'(1) == r_n) ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_nseq  <= 32'd1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_nseq  <= n_nseq;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_data;
        end
        if (r_state == S_FIND) begin
            r_hit <= find_hit;
            r_idx <= find_idx;
        end
        r_slot  <= n_slot;
        r_fresh <= n_fresh;
        r_evict <= n_evict;
        r_ptr   <= n_ptr;
        r_have  <= n_have;
        r_best  <= n_best;
        r_bseq  <= n_bseq;
        r_used  <= n_used;
        r_n     <= n_n;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_in.mode == MODE_CLEAR && out_free)
        |=> (r_count == '0 && r_nseq == 32'd1))
        else $error("clear left entries behind");

    a_list_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_have && r_k < r_n))
        else $error("list step without a candidate");

endmodule

// ===== sim/keyed_table_oldest_eviction_tb.sv =====
module keyed_table_oldest_eviction_tb
    import kto_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 32;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int sent_count = 0;
    int quiet_cycles = 0;
    t_out expected_results[$];

    logic [63:0] tbl_key [TABLE_DEPTH];
    t_entry      tbl_entry [TABLE_DEPTH];
    int          tbl_count;
    logic [31:0] tbl_next_seq;
    logic [63:0] key_pool [8];

    keyed_table_oldest_eviction dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out entry_result(logic [1:0] status, int idx, logic last);
        t_out r;
        r = '0;
        r.status = status;
        r.last = last;
        if (idx >= 0) begin
            r.out_key = tbl_key[idx];
            r.out_seq = tbl_entry[idx].seq;
            r.out_created_ms = tbl_entry[idx].created;
            r.out_updated_ms = tbl_entry[idx].updated;
            r.out_link_rssi = tbl_entry[idx].rssi;
            r.out_link_snr = tbl_entry[idx].snr;
            r.out_path_hash_size = tbl_entry[idx].path_size;
            r.out_path_hops = tbl_entry[idx].hops;
            r.out_favorite = tbl_entry[idx].flags[0];
            r.out_muted = tbl_entry[idx].flags[1];
        end
        return r;
    endfunction

    function automatic int find_entry(logic [63:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void stamp_entry(int idx, logic [31:0] now);
        tbl_entry[idx].seq = tbl_next_seq;
        tbl_entry[idx].updated = now;
        tbl_next_seq = tbl_next_seq + 32'd1;
    endfunction

    task automatic predict_table_op(t_in op);
        int idx;
        int slot;
        int n;
        int best;
        bit used [TABLE_DEPTH];
        logic [1:0] want;
        if (op.mode == MODE_LIST) begin
            n = (op.max_count > tbl_count) ? tbl_count : op.max_count;
            if (n == 0) begin
                expected_results.push_back(entry_result(ST_NOT_FOUND, -1, 1'b1));
                return;
            end
            foreach (used[i]) used[i] = 1'b0;
            for (int k = 0; k < n; k++) begin
                best = -1;
                for (int i = 0; i < tbl_count; i++) begin
                    if (!used[i] && (best < 0 || tbl_entry[i].seq > tbl_entry[best].seq))
                        best = i;
                end
                used[best] = 1'b1;
                expected_results.push_back(entry_result(ST_OK, best, k == n - 1));
            end
            return;
        end
        if (op.mode == MODE_CLEAR) begin
            tbl_count = 0;
            tbl_next_seq = 32'd1;
            expected_results.push_back(entry_result(ST_OK, -1, 1'b1));
            return;
        end
        if (op.mode > MODE_LIST) begin
            expected_results.push_back(entry_result(ST_INVALID, -1, 1'b1));
            return;
        end
        if (op.key == 0) begin
            expected_results.push_back(entry_result(
                op.mode == MODE_LOOKUP ? ST_NOT_FOUND : ST_INVALID, -1, 1'b1));
            return;
        end
        idx = find_entry(op.key);
        if (op.mode == MODE_UPSERT) begin
            if (idx >= 0) begin
                slot = idx;
            end else begin
                if (tbl_count < TABLE_DEPTH) begin
                    slot = tbl_count;
                    tbl_count++;
                end else begin
                    slot = 0;
                    for (int i = 1; i < TABLE_DEPTH; i++) begin
                        if (tbl_entry[i].seq < tbl_entry[slot].seq) slot = i;
                    end
                end
                tbl_key[slot] = op.key;
                tbl_entry[slot] = '0;
                tbl_entry[slot].created = op.now_ms;
            end
            stamp_entry(slot, op.now_ms);
            if (op.has_node) begin
                tbl_entry[slot].rssi = op.link_rssi;
                tbl_entry[slot].snr = op.link_snr;
                tbl_entry[slot].path_size = op.path_hash_size;
                tbl_entry[slot].hops = op.path_hop_count;
            end
            expected_results.push_back(entry_result(ST_OK, slot, 1'b1));
            return;
        end
        if (idx < 0) begin
            expected_results.push_back(entry_result(ST_NOT_FOUND, -1, 1'b1));
            return;
        end
        if (op.mode == MODE_FLAGS) begin
            want = {op.want_muted, op.want_favorite};
            if (tbl_entry[idx].flags != want) begin
                stamp_entry(idx, op.now_ms);
                tbl_entry[idx].flags = want;
            end
        end
        expected_results.push_back(entry_result(ST_OK, idx, 1'b1));
        if (op.mode == MODE_DELETE) begin
            for (int i = idx; i + 1 < tbl_count; i++) begin
                tbl_key[i] = tbl_key[i + 1];
                tbl_entry[i] = tbl_entry[i + 1];
            end
            tbl_count--;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_data.out_key, 64'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_data.status !== want.status)
                    report_mismatch("status", 64'(o_data.status), 64'(want.status));
                if (o_data.out_key !== want.out_key)
                    report_mismatch("key", o_data.out_key, want.out_key);
                if (o_data.out_seq !== want.out_seq)
                    report_mismatch("seq", 64'(o_data.out_seq), 64'(want.out_seq));
                if (o_data.out_created_ms !== want.out_created_ms)
                    report_mismatch("created", 64'(o_data.out_created_ms),
                                    64'(want.out_created_ms));
                if (o_data.out_updated_ms !== want.out_updated_ms)
                    report_mismatch("updated", 64'(o_data.out_updated_ms),
                                    64'(want.out_updated_ms));
                if (o_data.out_link_rssi !== want.out_link_rssi)
                    report_mismatch("rssi", 64'(o_data.out_link_rssi),
                                    64'(want.out_link_rssi));
                if (o_data.out_link_snr !== want.out_link_snr)
                    report_mismatch("snr", 64'(o_data.out_link_snr), 64'(want.out_link_snr));
                if (o_data.out_path_hash_size !== want.out_path_hash_size)
                    report_mismatch("path size", 64'(o_data.out_path_hash_size),
                                    64'(want.out_path_hash_size));
                if (o_data.out_path_hops !== want.out_path_hops)
                    report_mismatch("hops", 64'(o_data.out_path_hops),
                                    64'(want.out_path_hops));
                if (o_data.out_favorite !== want.out_favorite)
                    report_mismatch("favorite", 64'(o_data.out_favorite),
                                    64'(want.out_favorite));
                if (o_data.out_muted !== want.out_muted)
                    report_mismatch("muted", 64'(o_data.out_muted), 64'(want.out_muted));
                if (o_data.last !== want.last)
                    report_mismatch("last", 64'(o_data.last), 64'(want.last));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results pending", expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_op(t_in op);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_data <= op;
        i_valid <= 1'b1;
        predict_table_op(op);
        do @(posedge i_clk); while (!o_ready);
        sent_count++;
    endtask

    function automatic t_in make_op(logic [2:0] mode, logic [63:0] k);
        t_in op;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        op = raw[$bits(t_in)-1:0];
        op.mode = mode;
        op.key = k;
        op.max_count = 6'($urandom_range(32));
        return op;
    endfunction

    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 8) return key_pool[sel];
        return {$urandom, $urandom};
    endfunction

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed_modes();
        t_in op;
        op = make_op(MODE_LIST, 64'h0);
        op.max_count = 6'd32;
        send_op(op);
        send_op(make_op(MODE_LOOKUP, 64'h1));
        send_op(make_op(MODE_UPSERT, 64'h0));
        send_op(make_op(MODE_FLAGS, 64'h0));
        send_op(make_op(MODE_DELETE, 64'h0));
        send_op(make_op(MODE_LOOKUP, 64'h0));
        op = make_op(MODE_UPSERT, '1);
        op.has_node = 1'b1;
        op.link_rssi = 8'sh80;
        op.link_snr = 12'sh800;
        op.now_ms = '1;
        send_op(op);
        op = make_op(MODE_UPSERT, 64'h1);
        op.has_node = 1'b1;
        op.link_rssi = 8'sd127;
        op.link_snr = 12'sd2047;
        op.path_hash_size = '1;
        op.path_hop_count = '1;
        op.now_ms = '0;
        send_op(op);
        op = make_op(MODE_UPSERT, 64'h1);
        op.has_node = 1'b0;
        send_op(op);
        op = make_op(MODE_FLAGS, 64'h1);
        op.want_favorite = 1'b1;
        op.want_muted = 1'b1;
        send_op(op);
        send_op(op);
        send_op(make_op(MODE_FLAGS, 64'h77));
        send_op(make_op(MODE_LOOKUP, '1));
        send_op(make_op(3'd6, 64'h1));
        send_op(make_op(3'd7, 64'h1));
        op = make_op(MODE_LIST, 64'h0);
        op.max_count = '0;
        send_op(op);
        op.max_count = 6'd63;
        send_op(op);
        send_op(make_op(MODE_DELETE, '1));
        send_op(make_op(MODE_DELETE, 64'h55));
        send_op(make_op(MODE_CLEAR, 64'h0));
        send_op(make_op(MODE_LOOKUP, 64'h1));
        drain_results();
    endtask

    task automatic test_fill_and_evict();
        t_in op;
        for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
            op = make_op(MODE_UPSERT, 64'h100 + i);
            send_op(op);
            if (i == 10) send_op(make_op(MODE_FLAGS, 64'h100));
        end
        send_op(make_op(MODE_DELETE, 64'h110));
        op = make_op(MODE_LIST, 64'h0);
        op.max_count = 6'd32;
        send_op(op);
        send_op(make_op(MODE_UPSERT, 64'h200));
        send_op(make_op(MODE_UPSERT, 64'h201));
        drain_results();
    endtask

    task automatic test_random_ops(int count, int idle_pct, int stall_pct);
        t_in op;
        int sel;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) op = make_op(MODE_UPSERT, pick_key());
            else if (sel < 60) op = make_op(MODE_FLAGS, pick_key());
            else if (sel < 70) op = make_op(MODE_DELETE, pick_key());
            else if (sel < 82) op = make_op(MODE_LOOKUP, pick_key());
            else if (sel < 92) op = make_op(MODE_LIST, 64'h0);
            else if (sel < 94) op = make_op(MODE_CLEAR, 64'h0);
            else if (sel < 97) op = make_op(3'($urandom_range(7)), 64'h0);
            else op = make_op(3'($urandom_range(6, 7)), pick_key());
            send_op(op);
        end
        drain_results();
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom} | 64'h1;
        tbl_count = 0;
        tbl_next_seq = 32'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_modes();
        test_fill_and_evict();
        test_random_ops(24, 0, 0);
        test_random_ops(24, 52, 0);
        test_random_ops(24, 0, 52);
        test_random_ops(24, 37, 37);
        $display("Covered %0d operations and %0d results: every mode, eviction,", sent_count,
                 result_count);
        $display("delete compaction, list ordering and random idle and stall phases.");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== keyed_table_oldest_eviction.f =====
design/kto_pkg.sv
design/kto_cell.sv
design/keyed_table_oldest_eviction.sv
sim/keyed_table_oldest_eviction_tb.sv
